// File: src/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants of the linear-interpolating fractional delay.
// ----------------------------------------------------------------------------
package fdl_pkg;

   localparam int DEPTH_DEFAULT        = 1024;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   localparam int FRAC_BITS  = 16;
   localparam int DELAY_BITS = 26;
   localparam int GAIN_BITS  = 16;
   localparam int DINT_BITS  = DELAY_BITS - FRAC_BITS;
   localparam int CSR_WIDTH  = DELAY_BITS;

   localparam logic [DELAY_BITS-1:0]       DELAY_RESET = DELAY_BITS'(65536);
   localparam logic signed [GAIN_BITS-1:0] GAIN_RESET  = GAIN_BITS'(16384);

   typedef enum logic [0:0] {
      CSR_DELAY_AMOUNT = 1'b0,
      CSR_OUTPUT_GAIN  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SETUP_IDLE,
      SETUP_QUOT,
      SETUP_REDUCE,
      SETUP_OFFSET
   } setup_state_type;

endpackage

// File: src/fdl_setup.sv
// ----------------------------------------------------------------------------
// fdl_setup
// Turns a delay write into a read offset and interpolation fraction; the
// integer delay is reduced modulo DEPTH by a reciprocal multiply and one
// correcting subtract.
// ----------------------------------------------------------------------------
module fdl_setup
   import fdl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  delay_wr,
   input  logic [DELAY_BITS-1:0] delay_value,
   output logic [AW-1:0]         read_offset,
   output logic [FRAC_BITS-1:0]  frac,
   output logic                  busy
);

   localparam int QW      = 2 * DINT_BITS + 1;
   localparam int RECIP   = (1 << DINT_BITS) / DEPTH;
   localparam int CW      = (DINT_BITS > AW + 1) ? DINT_BITS : AW + 1;
   localparam logic [DINT_BITS:0]   RECIP_W  = (DINT_BITS + 1)'(RECIP);
   localparam logic [DINT_BITS-1:0] DEPTH_D  = DINT_BITS'(DEPTH);
   localparam logic [CW-1:0]        DEPTH_CW = CW'(DEPTH);
   localparam logic [AW:0]          DEPTH_W  = (AW + 1)'(DEPTH);

   setup_state_type        state_ff, state_in;
   logic [DINT_BITS-1:0]   rem_ff, rem_in;
   logic [DINT_BITS-1:0]   q_ff, q_in;
   logic [FRAC_BITS-1:0]   df_ff, df_in;
   logic [AW-1:0]          koff_ff, koff_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;

   logic [QW-1:0]          quot_full;
   logic [DINT_BITS-1:0]   qd;
   logic [DINT_BITS-1:0]   r1;
   logic                   ge;
   logic [AW:0]            dm;
   logic [AW:0]            koff_calc;

   // next state
   always_comb begin
      state_in = state_ff;
      if (delay_wr) begin
         state_in = SETUP_QUOT;
      end else begin
         unique case (state_ff)
            SETUP_IDLE:   state_in = SETUP_IDLE;
            SETUP_QUOT:   state_in = SETUP_REDUCE;
            SETUP_REDUCE: state_in = SETUP_OFFSET;
            SETUP_OFFSET: state_in = SETUP_IDLE;
         endcase
      end
   end

   // outputs
   always_comb begin
      busy        = (state_ff != SETUP_IDLE);
      read_offset = koff_ff;
      frac        = frac_ff;
   end

   // quotient estimate is exact or one low; one subtract corrects it
   always_comb begin
      quot_full = QW'(rem_ff) * QW'(RECIP_W);
      qd        = q_ff * DEPTH_D;
      r1        = rem_ff - qd;
      ge        = (CW'(r1) >= DEPTH_CW);
      dm        = (AW + 1)'(rem_ff);
      if (df_ff != '0) begin
         koff_calc = (dm == '0) ? '0 : DEPTH_W - dm;
      end else if (dm == '0) begin
         koff_calc = (AW + 1)'(1);
      end else if (dm == (AW + 1)'(1)) begin
         koff_calc = '0;
      end else begin
         koff_calc = DEPTH_W + (AW + 1)'(1) - dm;
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      df_in   = df_ff;
      koff_in = koff_ff;
      frac_in = frac_ff;
      if (delay_wr) begin
         rem_in  = delay_value[DELAY_BITS-1:FRAC_BITS];
         df_in   = delay_value[FRAC_BITS-1:0];
      end else if (state_ff == SETUP_QUOT) begin
         q_in    = quot_full[2*DINT_BITS-1:DINT_BITS];
      end else if (state_ff == SETUP_REDUCE) begin
         rem_in  = ge ? r1 - DEPTH_D : r1;
      end else if (state_ff == SETUP_OFFSET) begin
         koff_in = koff_calc[AW-1:0];
         frac_in = FRAC_BITS'(0) - df_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SETUP_IDLE;
         rem_ff   <= DELAY_RESET[DELAY_BITS-1:FRAC_BITS];
         df_ff    <= DELAY_RESET[FRAC_BITS-1:0];
         q_ff     <= '0;
         koff_ff  <= '0;   // delay 1.0: read the newest sample
         frac_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         df_ff    <= df_in;
         q_ff     <= q_in;
         koff_ff  <= koff_in;
         frac_ff  <= frac_in;
      end
   end

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      !busy |-> ({1'b0, koff_ff} < DEPTH_W))
      else $error("read offset out of range");

endmodule

// File: src/fdl_store.sv
// ----------------------------------------------------------------------------
// fdl_store
// Circular sample memory: two registered reads and one write per beat, with
// a fill mark so entries not yet written read as zero.
// ----------------------------------------------------------------------------
module fdl_store
   import fdl_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int AW           = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [SAMPLE_WIDTH-1:0] sample_in,
   input  logic [AW-1:0]           read_offset,
   output logic [SAMPLE_WIDTH-1:0] x1,
   output logic [SAMPLE_WIDTH-1:0] x2
);

   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

   logic [SAMPLE_WIDTH-1:0] mem [DEPTH];

   logic [AW-1:0] wp_ff, wp_in;
   logic          full_ff, full_in;
   logic [SAMPLE_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic          va_ff, vb_ff;

   logic [AW:0]   i_sum, i_wrap;
   logic [AW-1:0] addr_a, addr_b;
   logic          va, vb;

   always_comb begin
      i_sum  = {1'b0, wp_ff} + {1'b0, read_offset};
      i_wrap = (i_sum >= DEPTH_W) ? i_sum - DEPTH_W : i_sum;
      addr_a = i_wrap[AW-1:0];
      addr_b = (addr_a == LAST) ? '0 : addr_a + AW'(1);
      // entries 1..wp are written until the pointer first wraps
      va     = full_ff || ((addr_a != '0) && (addr_a <= wp_ff));
      vb     = full_ff || ((addr_b != '0) && (addr_b <= wp_ff));
      wp_in  = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);
      full_in = full_ff || (wp_in == '0);
   end

   // read-first: both reads see the store before this beat's write
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_in] <= sample_in;
         rd_a_ff    <= mem[addr_a];
         rd_b_ff    <= mem[addr_b];
         va_ff      <= va;
         vb_ff      <= vb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else if (accept) begin
         wp_ff   <= wp_in;
         full_ff <= full_in;
      end
   end

   assign x1 = va_ff ? rd_a_ff : '0;
   assign x2 = vb_ff ? rd_b_ff : '0;

   a_pointer_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (wp_ff != $past(wp_ff)))
      else $error("write pointer did not advance");

   a_full_sticks: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("fill mark dropped");

endmodule

// File: src/fdl_datapath.sv
// ----------------------------------------------------------------------------
// fdl_datapath
// Interpolate, apply gain, round and saturate; three stages plus output
// register, all advancing together unless the output is stalled.
// ----------------------------------------------------------------------------
module fdl_datapath
   import fdl_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [SAMPLE_WIDTH-1:0]     x1,
   input  logic [SAMPLE_WIDTH-1:0]     x2,
   input  logic [FRAC_BITS-1:0]        frac,
   input  logic signed [GAIN_BITS-1:0] gain,
   input  logic                        out_ready,
   output logic                        advance,
   output logic                        out_valid,
   output logic [SAMPLE_WIDTH-1:0]     out_sample
);

   localparam int SW = SAMPLE_WIDTH;
   localparam logic signed [SW+2:0] MAXV = {4'b0000, {(SW - 1){1'b1}}};
   localparam logic signed [SW+2:0] MINV = {4'b1111, {(SW - 1){1'b0}}};
   localparam logic signed [SW+32:0] HALF = (SW + 33)'(1 << 29);

   logic s1_ff, s2_ff, s3_ff, ov_ff;
   logic signed [SW+16:0] acc_ff;
   logic signed [33:0]    pl_ff;
   logic signed [SW+15:0] ph_ff;
   logic [SW-1:0]         out_ff;

   logic signed [SW:0]    diff;
   logic signed [SW+17:0] prod_m, acc_full;
   logic signed [SW+32:0] prod, rnd;
   logic signed [SW+2:0]  r;
   logic [SW-1:0]         sat;

   assign advance = !ov_ff || out_ready;

   // stage 1: acc = x1*2^16 + (x2 - x1)*f
   always_comb begin
      diff     = $signed({x2[SW-1], x2}) - $signed({x1[SW-1], x1});
      prod_m   = diff * $signed({1'b0, frac});
      acc_full = prod_m + $signed({{2{x1[SW-1]}}, x1, 16'b0});
   end

   // stage 3: recombine split product, round half up, saturate
   always_comb begin
      prod = $signed({ph_ff, 17'b0}) + (SW + 33)'(pl_ff);
      rnd  = prod + HALF;
      r    = rnd[SW+32:30];
      if (r > MAXV)      sat = MAXV[SW-1:0];
      else if (r < MINV) sat = MINV[SW-1:0];
      else               sat = r[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_full[SW+16:0];
         pl_ff  <= $signed({1'b0, acc_ff[16:0]}) * gain;
         ph_ff  <= $signed(acc_ff[SW+16:17]) * gain;
         out_ff <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (advance) begin
         s1_ff <= accept;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         ov_ff <= s3_ff;
      end
   end

   assign out_valid  = ov_ff;
   assign out_sample = out_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!advance && s3_ff) |=> s3_ff)
      else $error("beat lost in stalled pipeline");

endmodule

// File: src/fractional_delay_linear.sv
// ----------------------------------------------------------------------------
// fractional_delay_linear
// Fractional delay line with linear interpolation and output gain.
//
// Usage:
//  - req_ channel: one signed sample per beat (valid/ready).
//  - rsp_ channel: one delayed, interpolated, gain-scaled sample per input
//    beat, in order (valid/ready).
//  - csr_ port: index 0 = delay (unsigned Q.16, 26 bits), index 1 = gain
//    (signed Q2.14, 16 bits); written by a single-cycle enable.
//  - A beat passes store read, acc, product and output registers to rsp_.
//  - Throughput: one beat per cycle when not stalled or busy; the sample
//    memory serves both taps and the new sample's write in the accept cycle.
//  - A delay write steps through quotient by reciprocal multiply, one
//    correcting subtract and offset to reduce the integer delay modulo
//    DEPTH; req_ready is low meanwhile.
//  - Reset: pointer to zero, delay 1.0, unity gain; unwritten memory entries
//    read as zero through a fill mark, so no clearing pass is needed.
//  - When rsp_ready is low with a result held, the whole pipeline freezes
//    and req_ready drops in the same cycle; no beat is lost.
// ----------------------------------------------------------------------------
module fractional_delay_linear
   import fdl_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // input samples
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_in,
   // output samples
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   // configuration
   input  logic                    csr_write_en,
   input  logic [0:0]              csr_index,
   input  logic [CSR_WIDTH-1:0]    csr_write_data
);

   localparam int AW = $clog2(DEPTH);

   logic                        accept;
   logic                        advance;
   logic                        busy;
   logic                        delay_wr;
   logic [AW-1:0]               read_offset;
   logic [FRAC_BITS-1:0]        frac;
   logic [SAMPLE_WIDTH-1:0]     x1, x2;
   logic signed [GAIN_BITS-1:0] gain_ff, gain_in;

   // register decode
   always_comb begin
      delay_wr = 1'b0;
      gain_in  = gain_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY_AMOUNT: delay_wr = 1'b1;
            CSR_OUTPUT_GAIN:  gain_in  = csr_write_data[GAIN_BITS-1:0];
            default:          gain_in  = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // take a beat only when the pipeline moves and the offset is settled
   assign req_ready = advance && !busy;
   assign accept    = req_valid && req_ready;

   fdl_setup #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_setup (
      .clock       (clock),
      .reset       (reset),
      .delay_wr    (delay_wr),
      .delay_value (csr_write_data[DELAY_BITS-1:0]),
      .read_offset (read_offset),
      .frac        (frac),
      .busy        (busy)
   );

   fdl_store #(
      .DEPTH        (DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AW           (AW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .sample_in   (req_sample_in),
      .read_offset (read_offset),
      .x1          (x1),
      .x2          (x2)
   );

   fdl_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .x1         (x1),
      .x2         (x2),
      .frac       (frac),
      .gain       (gain_ff),
      .out_ready  (rsp_ready),
      .advance    (advance),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample_out)
   );

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("beat accepted during delay setup");

endmodule
